// ===== src/stip_pkg.sv =====
package stip_pkg;

   localparam int COORD_W = 32;
   localparam int REQ_W = 9 * COORD_W;
   localparam int RSP_W = 24;
   localparam int CSR_IDX_W = 3;
   localparam int LIM_W = 16;

   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_W = PARAM_FRAC_BITS + 1;

   localparam int MUL_LAT = 4;

   localparam int DIFF_W = COORD_W + 1;
   localparam int NORM_W = 2 * DIFF_W + 1;
   localparam int PLANE_W = NORM_W + DIFF_W + 3;
   localparam int DIV_W = PLANE_W + PARAM_W;
   localparam int GRAM_W = 2 * DIFF_W + 2;
   localparam int QD_W = PARAM_W + 1 + DIFF_W;
   localparam int W_W = COORD_W + 4;
   localparam int WDOT_W = W_W + DIFF_W + 2;
   localparam int DET_W = GRAM_W + WDOT_W + 3;

   typedef enum logic [2:0] {
      CAUSE_HIT         = 3'd0,
      CAUSE_DEGENERATE  = 3'd1,
      CAUSE_PARALLEL    = 3'd2,
      CAUSE_OUTSIDE_SEG = 3'd3,
      CAUSE_OUTSIDE_TRI = 3'd4
   } cause_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X   = 3'd0,
      CSR_START_Y   = 3'd1,
      CSR_START_Z   = 3'd2,
      CSR_END_X     = 3'd3,
      CSR_END_Y     = 3'd4,
      CSR_END_Z     = 3'd5,
      CSR_NEAR_ZERO = 3'd6
   } csr_index_type;

endpackage

// ===== src/stip_mul.sv =====
module stip_mul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);

   localparam int PW = AW + BW;
   localparam int DG = 32;
   localparam int NA = (AW + DG - 1) / DG;
   localparam int NB = (BW + DG - 1) / DG;
   localparam int SW = (NA + NB) * DG;

   logic [AW-1:0]      am;
   logic [BW-1:0]      bm;
   logic [NA*DG-1:0]   ma_ff;
   logic [NB*DG-1:0]   mb_ff;
   logic               neg1_ff, neg2_ff, neg3_ff;
   logic [2*DG-1:0]    pp_ff [NA*NB];
   logic [SW-1:0]      sum_in;
   logic [PW-1:0]      mag_ff;
   logic signed [PW-1:0] p_ff;

   always_comb begin
      am = a[AW-1] ? $unsigned(-a) : $unsigned(a);
      bm = b[BW-1] ? $unsigned(-b) : $unsigned(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= (NA*DG)'(am);
         mb_ff <= (NB*DG)'(bm);
         neg1_ff <= a[AW-1] ^ b[BW-1];
         neg2_ff <= neg1_ff;
         neg3_ff <= neg2_ff;
      end
   end

   for (genvar i = 0; i < NA; i++) begin : g_row
      for (genvar j = 0; j < NB; j++) begin : g_col
         always_ff @(posedge clock) begin
            if (en) begin
               pp_ff[i*NB+j] <= ma_ff[i*DG +: DG] * mb_ff[j*DG +: DG];
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (SW'(pp_ff[i*NB+j]) << (DG * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= sum_in[PW-1:0];
         p_ff <= neg3_ff ? -$signed(mag_ff) : $signed(mag_ff);
      end
   end

   assign p = p_ff;

endmodule

// ===== src/stip_delay.sv =====
module stip_delay #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int k = 1; k < D; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q = tap_ff[D-1];

endmodule

// ===== src/stip_div.sv =====
module stip_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [stip_pkg::PLANE_W-1:0]  num,
   input  logic [stip_pkg::PLANE_W-1:0]  den,
   output logic [stip_pkg::PARAM_W-1:0]  quo
);

   localparam int N = stip_pkg::PARAM_W;
   localparam int DW = stip_pkg::DIV_W;
   localparam int PWD = stip_pkg::PLANE_W;

   logic [DW-1:0]  rem_ff [N];
   logic [PWD-1:0] den_ff [N];
   logic [N-1:0]   quo_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [DW-1:0]  rem_prev;
      logic [DW-1:0]  sub;
      logic [PWD-1:0] den_prev;
      logic [N-1:0]   quo_prev;

      if (k == 0) begin : g_first
         assign rem_prev = DW'(num) << stip_pkg::PARAM_FRAC_BITS;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign sub = DW'(den_prev) << (N - 1 - k);

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_prev;
            if (sub <= rem_prev) begin
               rem_ff[k] <= rem_prev - sub;
               quo_ff[k] <= quo_prev | (N'(1) << (N - 1 - k));
            end else begin
               rem_ff[k] <= rem_prev;
               quo_ff[k] <= quo_prev;
            end
         end
      end
   end

   assign quo = quo_ff[N-1];

endmodule

// ===== src/segment_triangle_intersect_unit.sv =====
// Channel  Dir  Fields (lowest bit first)
// req      in   tdata: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z (32 bits each)
// rsp      out  tdata: hit, seg_param[16:0], miss_cause[2:0], 3 zero bits
// csr      in   write enable, index 0..6, 32-bit data
//
// One item enters per cycle unless a stalled result holds the pipeline.
// The pipeline depth is set by the 17-step restoring divider and the chained
// multipliers for the normal, plane, and Gram determinant terms.
// Reset is synchronous; it clears the valid bits and the segment registers and sets the near-zero limit to 1.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module segment_triangle_intersect_unit #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [stip_pkg::REQ_W-1:0]    req_tdata,  // v0_x v0_y v0_z v1_x .. v2_z
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [stip_pkg::RSP_W-1:0]    rsp_tdata,  // hit, seg_param, miss_cause
   input  logic                          csr_we,
   input  logic [stip_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stip_pkg::COORD_W-1:0]  csr_wdata
);

   localparam int CW = stip_pkg::COORD_W;
   localparam int DFW = stip_pkg::DIFF_W;
   localparam int NW = stip_pkg::NORM_W;
   localparam int PLW = stip_pkg::PLANE_W;
   localparam int GW = stip_pkg::GRAM_W;
   localparam int QW = stip_pkg::PARAM_W;
   localparam int QDW = stip_pkg::QD_W;
   localparam int WW = stip_pkg::W_W;
   localparam int WDW = stip_pkg::WDOT_W;
   localparam int DTW = stip_pkg::DET_W;
   localparam int ML = stip_pkg::MUL_LAT;

   localparam int T_A = 1;
   localparam int T_N = T_A + ML + 1;
   localparam int T_S = T_N + ML + 1;
   localparam int T_NB = T_S + 1;
   localparam int T_E = T_NB + 1;
   localparam int T_Q = T_NB + QW;
   localparam int T_W = T_Q + 2;
   localparam int T_F = T_W + ML + 1;
   localparam int T_G = T_F + ML + 1;
   localparam int T_OUT = T_G + 3;

   logic signed [CW-1:0]  seg_ff [6];
   logic [stip_pkg::LIM_W-1:0] nzl_ff;
   logic                  adv;
   logic [T_OUT:1]        vld_ff;

   logic signed [CW-1:0]  vin [9];
   logic signed [CW-1:0]  p0_ff [3];
   logic signed [DFW-1:0] u_ff [3], v_ff [3], w0_ff [3], dir_ff [3];

   logic signed [2*DFW-1:0] cpa [3], cpb [3], puu [3], puv [3], pvv [3];
   logic signed [NW-1:0]  n_ff [3];
   logic [NW-1:0]         absn [3];
   logic [NW-1:0]         lim1;
   logic signed [GW-1:0]  uu_ff, uv_ff, vv_ff;
   logic                  deg1_ff, deg1_d;

   logic [DFW-1:0]        w0_n [3], dir_n [3], dir_q [3], u_w [3], v_w [3];
   logic [CW-1:0]         p0_q [3];
   logic signed [NW+DFW-1:0] pa [3], pb [3];
   logic signed [PLW-1:0] sa_ff, sb_ff, an_ff, bn_ff;
   logic [PLW-1:0]        lim2;
   logic [2:0]            ecause_ff, ecause_d;

   logic [QW-1:0]         q, q_d;
   logic signed [QDW-1:0] qd_ff [3];
   logic signed [WW-1:0]  w_ff [3];
   logic signed [WW+DFW-1:0] pwu [3], pwv [3];
   logic signed [WDW-1:0] wu_ff, wv_ff;
   logic [GW-1:0]         uu_f, uv_f, vv_f;

   logic signed [2*GW-1:0]   p_uvuv, p_uuvv;
   logic signed [GW+WDW-1:0] p_uvwv, p_vvwu, p_uvwu, p_uuwv;
   logic signed [DTW-1:0] dm_ff, sn_ff, tn_ff, dmn_ff, snn_ff, tnn_ff;
   logic                  dmz_ff, dmz2_ff, outtri_ff;

   logic                  hit_ff;
   logic [QW-1:0]         param_ff;
   stip_pkg::cause_type   cause_ff, cause_in;

   assign adv = !vld_ff[T_OUT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[T_OUT];
   assign rsp_tdata = {(stip_pkg::RSP_W - QW - 4)'(0), cause_ff, param_ff, hit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            seg_ff[i] <= '0;
         end
         nzl_ff <= stip_pkg::LIM_W'(1);
      end else if (csr_we) begin
         case (stip_pkg::csr_index_type'(csr_index))
            stip_pkg::CSR_START_X, stip_pkg::CSR_START_Y, stip_pkg::CSR_START_Z,
            stip_pkg::CSR_END_X, stip_pkg::CSR_END_Y, stip_pkg::CSR_END_Z: begin
               seg_ff[csr_index] <= $signed(csr_wdata);
            end
            stip_pkg::CSR_NEAR_ZERO: begin
               nzl_ff <= csr_wdata[stip_pkg::LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[T_OUT-1:1], req_tvalid};
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         vin[k] = $signed(req_tdata[CW*k +: CW]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p0_ff[i] <= vin[i];
            u_ff[i] <= DFW'(vin[3+i]) - DFW'(vin[i]);
            v_ff[i] <= DFW'(vin[6+i]) - DFW'(vin[i]);
            w0_ff[i] <= DFW'(seg_ff[i]) - DFW'(vin[i]);
            dir_ff[i] <= DFW'(seg_ff[3+i]) - DFW'(seg_ff[i]);
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_front
      stip_mul #(.AW(DFW), .BW(DFW)) u_cpa (
         .clock(clock), .en(adv), .a(u_ff[(c+1)%3]), .b(v_ff[(c+2)%3]), .p(cpa[c]));
      stip_mul #(.AW(DFW), .BW(DFW)) u_cpb (
         .clock(clock), .en(adv), .a(u_ff[(c+2)%3]), .b(v_ff[(c+1)%3]), .p(cpb[c]));
      stip_mul #(.AW(DFW), .BW(DFW)) u_puu (
         .clock(clock), .en(adv), .a(u_ff[c]), .b(u_ff[c]), .p(puu[c]));
      stip_mul #(.AW(DFW), .BW(DFW)) u_puv (
         .clock(clock), .en(adv), .a(u_ff[c]), .b(v_ff[c]), .p(puv[c]));
      stip_mul #(.AW(DFW), .BW(DFW)) u_pvv (
         .clock(clock), .en(adv), .a(v_ff[c]), .b(v_ff[c]), .p(pvv[c]));

      stip_delay #(.W(DFW), .D(T_N - T_A)) u_w0_n (
         .clock(clock), .en(adv), .d(w0_ff[c]), .q(w0_n[c]));
      stip_delay #(.W(DFW), .D(T_N - T_A)) u_dir_n (
         .clock(clock), .en(adv), .d(dir_ff[c]), .q(dir_n[c]));
      stip_delay #(.W(DFW), .D(T_Q - T_A)) u_dir_q (
         .clock(clock), .en(adv), .d(dir_ff[c]), .q(dir_q[c]));
      stip_delay #(.W(CW), .D(T_Q + 1 - T_A)) u_p0_q (
         .clock(clock), .en(adv), .d(p0_ff[c]), .q(p0_q[c]));
      stip_delay #(.W(DFW), .D(T_W - T_A)) u_u_w (
         .clock(clock), .en(adv), .d(u_ff[c]), .q(u_w[c]));
      stip_delay #(.W(DFW), .D(T_W - T_A)) u_v_w (
         .clock(clock), .en(adv), .d(v_ff[c]), .q(v_w[c]));

      stip_mul #(.AW(NW), .BW(DFW)) u_pa (
         .clock(clock), .en(adv), .a(n_ff[c]), .b($signed(w0_n[c])), .p(pa[c]));
      stip_mul #(.AW(NW), .BW(DFW)) u_pb (
         .clock(clock), .en(adv), .a(n_ff[c]), .b($signed(dir_n[c])), .p(pb[c]));

      stip_mul #(.AW(WW), .BW(DFW)) u_pwu (
         .clock(clock), .en(adv), .a(w_ff[c]), .b($signed(u_w[c])), .p(pwu[c]));
      stip_mul #(.AW(WW), .BW(DFW)) u_pwv (
         .clock(clock), .en(adv), .a(w_ff[c]), .b($signed(v_w[c])), .p(pwv[c]));
   end

   always_comb begin
      lim1 = NW'(nzl_ff) << COORD_FRAC_BITS;
      for (int c = 0; c < 3; c++) begin
         absn[c] = n_ff[c][NW-1] ? $unsigned(-n_ff[c]) : $unsigned(n_ff[c]);
      end
      lim2 = PLW'(nzl_ff) << (2 * COORD_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            n_ff[c] <= NW'(cpa[c]) - NW'(cpb[c]);
         end
         uu_ff <= GW'(puu[0]) + GW'(puu[1]) + GW'(puu[2]);
         uv_ff <= GW'(puv[0]) + GW'(puv[1]) + GW'(puv[2]);
         vv_ff <= GW'(pvv[0]) + GW'(pvv[1]) + GW'(pvv[2]);
         deg1_ff <= (absn[0] < lim1) && (absn[1] < lim1) && (absn[2] < lim1);

         sa_ff <= PLW'(pa[0]) + PLW'(pa[1]) + PLW'(pa[2]);
         sb_ff <= PLW'(pb[0]) + PLW'(pb[1]) + PLW'(pb[2]);
         an_ff <= sb_ff[PLW-1] ? sa_ff : -sa_ff;
         bn_ff <= sb_ff[PLW-1] ? -sb_ff : sb_ff;

         if (deg1_d) begin
            ecause_ff <= stip_pkg::CAUSE_DEGENERATE;
         end else if (bn_ff == '0 || $unsigned(bn_ff) < lim2) begin
            ecause_ff <= stip_pkg::CAUSE_PARALLEL;
         end else if (an_ff[PLW-1] || an_ff > bn_ff) begin
            ecause_ff <= stip_pkg::CAUSE_OUTSIDE_SEG;
         end else begin
            ecause_ff <= stip_pkg::CAUSE_HIT;
         end
      end
   end

   stip_delay #(.W(1), .D(T_NB - T_N - 1)) u_deg1_d (
      .clock(clock), .en(adv), .d(deg1_ff), .q(deg1_d));

   stip_div u_div (
      .clock(clock), .en(adv), .num($unsigned(an_ff)), .den($unsigned(bn_ff)), .quo(q));

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            qd_ff[c] <= $signed({1'b0, q}) * $signed(dir_q[c]);
            w_ff[c] <= WW'(seg_ff[c]) + WW'(qd_ff[c] >>> stip_pkg::PARAM_FRAC_BITS)
                       - WW'($signed(p0_q[c]));
         end
         wu_ff <= WDW'(pwu[0]) + WDW'(pwu[1]) + WDW'(pwu[2]);
         wv_ff <= WDW'(pwv[0]) + WDW'(pwv[1]) + WDW'(pwv[2]);
      end
   end

   stip_delay #(.W(GW), .D(T_F - T_N)) u_uu_f (
      .clock(clock), .en(adv), .d(uu_ff), .q(uu_f));
   stip_delay #(.W(GW), .D(T_F - T_N)) u_uv_f (
      .clock(clock), .en(adv), .d(uv_ff), .q(uv_f));
   stip_delay #(.W(GW), .D(T_F - T_N)) u_vv_f (
      .clock(clock), .en(adv), .d(vv_ff), .q(vv_f));

   stip_mul #(.AW(GW), .BW(GW)) u_uvuv (
      .clock(clock), .en(adv), .a($signed(uv_f)), .b($signed(uv_f)), .p(p_uvuv));
   stip_mul #(.AW(GW), .BW(GW)) u_uuvv (
      .clock(clock), .en(adv), .a($signed(uu_f)), .b($signed(vv_f)), .p(p_uuvv));
   stip_mul #(.AW(GW), .BW(WDW)) u_uvwv (
      .clock(clock), .en(adv), .a($signed(uv_f)), .b(wv_ff), .p(p_uvwv));
   stip_mul #(.AW(GW), .BW(WDW)) u_vvwu (
      .clock(clock), .en(adv), .a($signed(vv_f)), .b(wu_ff), .p(p_vvwu));
   stip_mul #(.AW(GW), .BW(WDW)) u_uvwu (
      .clock(clock), .en(adv), .a($signed(uv_f)), .b(wu_ff), .p(p_uvwu));
   stip_mul #(.AW(GW), .BW(WDW)) u_uuwv (
      .clock(clock), .en(adv), .a($signed(uu_f)), .b(wv_ff), .p(p_uuwv));

   stip_delay #(.W(3), .D(T_G + 2 - T_E)) u_ecause_d (
      .clock(clock), .en(adv), .d(ecause_ff), .q(ecause_d));
   stip_delay #(.W(QW), .D(T_G + 2 - T_Q)) u_q_d (
      .clock(clock), .en(adv), .d(q), .q(q_d));

   always_ff @(posedge clock) begin
      if (adv) begin
         dm_ff <= DTW'(p_uvuv) - DTW'(p_uuvv);
         sn_ff <= DTW'(p_uvwv) - DTW'(p_vvwu);
         tn_ff <= DTW'(p_uvwu) - DTW'(p_uuwv);

         dmz_ff <= (dm_ff == '0);
         dmn_ff <= dm_ff[DTW-1] ? -dm_ff : dm_ff;
         snn_ff <= dm_ff[DTW-1] ? -sn_ff : sn_ff;
         tnn_ff <= dm_ff[DTW-1] ? -tn_ff : tn_ff;

         dmz2_ff <= dmz_ff;
         outtri_ff <= snn_ff[DTW-1] || (snn_ff > dmn_ff) || tnn_ff[DTW-1] ||
                      ((snn_ff + tnn_ff) > dmn_ff);
      end
   end

   always_comb begin
      if (stip_pkg::cause_type'(ecause_d) != stip_pkg::CAUSE_HIT) begin
         cause_in = stip_pkg::cause_type'(ecause_d);
      end else if (dmz2_ff) begin
         cause_in = stip_pkg::CAUSE_DEGENERATE;
      end else if (outtri_ff) begin
         cause_in = stip_pkg::CAUSE_OUTSIDE_TRI;
      end else begin
         cause_in = stip_pkg::CAUSE_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cause_ff <= cause_in;
         hit_ff <= (cause_in == stip_pkg::CAUSE_HIT);
         param_ff <= (cause_in == stip_pkg::CAUSE_HIT) ? q_d : '0;
      end
   end

`ifndef SYNTHESIS
   a_hit_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hit_ff == (cause_ff == stip_pkg::CAUSE_HIT)))
      else $error("hit flag disagrees with miss cause");

   a_miss_param: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit_ff) |-> (param_ff == '0))
      else $error("segment parameter nonzero on a miss");

   a_param_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && hit_ff) |-> (param_ff <= (QW'(1) << stip_pkg::PARAM_FRAC_BITS)))
      else $error("segment parameter beyond segment end");
`endif

endmodule
